FILE: rtl/core/cbs_pkg.sv
// Package for the cubic Bezier splat block: sequencer states and shared constants.
`default_nettype none
package cbs_pkg;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BERN,
        ST_ROUND,
        ST_READ,
        ST_WRITE,
        ST_OUT
    } t_state;

    localparam int NUM_REGS  = 8;
    localparam int REG_W     = 10;
    localparam int IDX_W     = 3;
    localparam int COORD_W   = 11;
    localparam int BYTE_W    = 8;
    localparam int PIXEL_W   = 24;

    // Channel codes
    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;
    localparam logic [1:0] CH_NONE  = 2'd3;   // no byte selected, nothing written

    // Sequencer step where the Bernstein weights are done and point products start
    localparam logic [3:0] STEP_PTS  = 4'd6;
    localparam logic [3:0] STEP_LAST = 4'd13;

endpackage
`default_nettype wire

FILE: rtl/core/cbs_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none
module cbs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1048576
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: rtl/core/cubic_bezier_splat.sv
// Top level of the cubic Bezier splat: curve evaluation and antialiased frame update.
// The first result is registered after the multiply steps, rounding, and a pixel read.
// A new item is taken only in the idle state, once the last is done: 14 multiply
//   steps on the one shared multiplier, 1 rounding step, then a read, write and output
//   state for each pixel on the single frame memory port, waiting for i_out_ready.
// Reset: synchronous, active low; clears control state and the 8 point registers, then
//   a clearing pass zeroes all FRAME_WIDTH*FRAME_HEIGHT words before the first item.
`default_nettype none
module cubic_bezier_splat #(
    parameter int FRAME_WIDTH  = 1024,
    parameter int FRAME_HEIGHT = 1024,
    parameter int T_FRAC_BITS  = 16
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [cbs_pkg::IDX_W-1:0]     i_cfg_idx,
    input  wire logic [cbs_pkg::REG_W-1:0]     i_cfg_data,
    // input channel
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [T_FRAC_BITS:0]          i_sample_t,
    input  wire logic [1:0]                    i_channel,
    // result channel
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic [cbs_pkg::COORD_W-1:0]        o_pixel_x,
    output logic [cbs_pkg::COORD_W-1:0]        o_pixel_y,
    output logic [cbs_pkg::BYTE_W-1:0]         o_new_value,
    output logic                               o_in_frame,
    output logic                               o_last
);
    import cbs_pkg::*;

    localparam int TW    = T_FRAC_BITS + 1;              // Q1.T incl. the value one
    localparam int AMW   = T_FRAC_BITS + 3;              // multiplier A (holds 3*weight)
    localparam int BW    = (TW > REG_W) ? TW : REG_W;    // multiplier B
    localparam int PW    = AMW + BW;                     // product
    localparam int CW    = T_FRAC_BITS + 12;             // curve coordinate Q12.T
    localparam int DEPTH = FRAME_WIDTH * FRAME_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XW    = CW - T_FRAC_BITS;

    localparam logic [TW-1:0] ONE_T  = {1'b1, {T_FRAC_BITS{1'b0}}};
    localparam logic [CW-1:0] HALF_C = CW'(1) << (T_FRAC_BITS - 1);
    localparam logic [PW-1:0] HALF_P = PW'(1) << (T_FRAC_BITS - 1);

    t_state r_state, n_state;

    // control point registers, indexed in config order
    logic [REG_W-1:0] r_pt [NUM_REGS];

    logic [TW-1:0]    r_t;
    logic [1:0]       r_ch;
    logic [3:0]       r_step;
    logic [1:0]       r_pix;
    logic [TW-1:0]    r_s2, r_t2, r_b0, r_b3;
    logic [AMW-1:0]   r_b1, r_b2;
    logic [CW-1:0]    r_cx, r_cy;
    logic [COORD_W-1:0] r_x, r_y, r_left, r_upper;
    logic [TW-1:0]    r_wl, r_wr, r_wh, r_wlow;
    logic [BYTE_W-1:0] r_amt;
    logic [AW-1:0]    r_clr;

    // shared multiplier
    logic [AMW-1:0]   mul_a;
    logic [BW-1:0]    mul_b;
    logic [PW-1:0]    prod;
    logic [PW-1:0]    prod_rnd_full;
    logic [TW-1:0]    prod_rnd;
    logic [AMW-1:0]   prod_rnd3;
    logic [PW+7:0]    prod255;

    logic [TW-1:0]    s_val;
    logic [3:0]       step_m6;
    logic [AMW-1:0]   b_sel;

    // curve rounding
    logic [CW-1:0]    cx_h, cy_h;
    logic [XW-1:0]    x_full, y_full;
    logic [CW-1:0]    wl_full, wh_full;

    // pixel update
    logic [COORD_W-1:0] col, row;
    logic [TW-1:0]    w_a, w_b;
    logic             pix_ok;
    logic [AW-1:0]    pix_addr;
    logic [PIXEL_W-1:0] rd_data;
    logic [BYTE_W-1:0] old_byte;
    logic [BYTE_W:0]  sum;
    logic [BYTE_W-1:0] sat;
    logic [PIXEL_W-1:0] upd_word;
    logic             ram_we;
    logic [AW-1:0]    ram_waddr;
    logic [PIXEL_W-1:0] ram_wdata;

    assign s_val   = ONE_T - r_t;
    assign step_m6 = r_step - STEP_PTS;

    // Bernstein weight for the point product steps: two steps (x, y) per weight
    always_comb begin
        case (step_m6[2:1])
            2'd0:    b_sel = AMW'(r_b0);
            2'd1:    b_sel = r_b1;
            2'd2:    b_sel = r_b2;
            default: b_sel = AMW'(r_b3);
        endcase
    end

    // pixel order: (left,y) (x,y) (left,upper) (x,upper)
    assign col = r_pix[0] ? r_x : r_left;
    assign row = r_pix[1] ? r_upper : r_y;
    assign w_a = r_pix[0] ? r_wr : r_wl;
    assign w_b = r_pix[1] ? r_wlow : r_wh;

    // operand select for the shared multiplier
    always_comb begin
        mul_a = AMW'(s_val);
        mul_b = BW'(s_val);
        if (r_state == ST_BERN) begin
            case (r_step)
                4'd0: begin mul_a = AMW'(s_val); mul_b = BW'(s_val); end
                4'd1: begin mul_a = AMW'(r_t);   mul_b = BW'(r_t);   end
                4'd2: begin mul_a = AMW'(r_s2);  mul_b = BW'(s_val); end
                4'd3: begin mul_a = AMW'(r_s2);  mul_b = BW'(r_t);   end
                4'd4: begin mul_a = AMW'(r_t2);  mul_b = BW'(s_val); end
                4'd5: begin mul_a = AMW'(r_t2);  mul_b = BW'(r_t);   end
                default: begin
                    mul_a = b_sel;
                    mul_b = BW'(r_pt[step_m6[IDX_W-1:0]]);
                end
            endcase
        end else if (r_state == ST_READ) begin
            mul_a = AMW'(w_a);
            mul_b = BW'(w_b);
        end
    end

    assign prod          = PW'(mul_a) * PW'(mul_b);
    assign prod_rnd_full = prod + HALF_P;
    assign prod_rnd      = prod_rnd_full[T_FRAC_BITS +: TW];
    assign prod_rnd3     = {prod_rnd, 1'b0} + AMW'(prod_rnd);
    // 255*p = (p << 8) - p; the weight product never exceeds one squared
    assign prod255       = {prod, 8'd0} - (PW+8)'(prod);

    // half-up rounding to whole pixels and bilinear weights
    assign cx_h    = r_cx + HALF_C;
    assign cy_h    = r_cy + HALF_C;
    assign x_full  = cx_h[CW-1:T_FRAC_BITS];
    assign y_full  = cy_h[CW-1:T_FRAC_BITS];
    assign wl_full = {x_full, {T_FRAC_BITS{1'b0}}} + HALF_C - r_cx;
    assign wh_full = cy_h - {y_full, {T_FRAC_BITS{1'b0}}};

    // frame memory access
    assign pix_ok   = ({2'b0, col} < (COORD_W+2)'(FRAME_WIDTH))
                    && ({2'b0, row} < (COORD_W+2)'(FRAME_HEIGHT))
                    && (r_ch != CH_NONE);
    assign pix_addr = AW'(row) * AW'(FRAME_WIDTH) + AW'(col);

    always_comb begin
        case (r_ch)
            CH_BLUE:  old_byte = rd_data[7:0];
            CH_GREEN: old_byte = rd_data[15:8];
            CH_RED:   old_byte = rd_data[23:16];
            default:  old_byte = '0;
        endcase
    end

    assign sum = {1'b0, old_byte} + {1'b0, r_amt};
    assign sat = sum[BYTE_W] ? {BYTE_W{1'b1}} : sum[BYTE_W-1:0];

    always_comb begin
        upd_word = rd_data;
        case (r_ch)
            CH_BLUE:  upd_word[7:0]   = sat;
            CH_GREEN: upd_word[15:8]  = sat;
            CH_RED:   upd_word[23:16] = sat;
            default:  upd_word        = rd_data;
        endcase
    end

    // write port shared by the clearing pass and the pixel update
    always_comb begin
        if (r_state == ST_CLEAR) begin
            ram_we    = 1'b1;
            ram_waddr = r_clr;
            ram_wdata = '0;
        end else begin
            ram_we    = (r_state == ST_WRITE) && pix_ok;
            ram_waddr = pix_addr;
            ram_wdata = upd_word;
        end
    end

    cbs_ram #(
        .WIDTH (PIXEL_W),
        .DEPTH (DEPTH)
    ) u_frame (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (pix_addr),
        .o_rdata (rd_data)
    );

    assign o_in_ready = (r_state == ST_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: if (r_clr == AW'(DEPTH - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_in_valid) n_state = ST_BERN;
            ST_BERN:  if (r_step == STEP_LAST) n_state = ST_ROUND;
            ST_ROUND: n_state = ST_READ;
            ST_READ:  n_state = ST_WRITE;
            ST_WRITE: n_state = ST_OUT;
            ST_OUT: begin
                if (i_out_ready) begin
                    n_state = (r_pix == 2'd3) ? ST_IDLE : ST_READ;
                end
            end
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    // control counters and point registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr       <= '0;
            r_step      <= '0;
            r_pix       <= '0;
            o_out_valid <= 1'b0;
            for (int i = 0; i < NUM_REGS; i++) begin
                r_pt[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_pt[i_cfg_idx] <= i_cfg_data;
            end
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + AW'(1);
            end
            if (r_state == ST_IDLE) begin
                r_step <= '0;
                r_pix  <= '0;
            end
            if (r_state == ST_BERN) begin
                r_step <= r_step + 4'd1;
            end
            if (r_state == ST_WRITE) begin
                o_out_valid <= 1'b1;
            end
            if (r_state == ST_OUT && i_out_ready) begin
                o_out_valid <= 1'b0;
                r_pix       <= r_pix + 2'd1;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == ST_IDLE) begin
            r_t  <= (i_sample_t > ONE_T) ? ONE_T : i_sample_t;
            r_ch <= i_channel;
            r_cx <= '0;
            r_cy <= '0;
        end
        if (r_state == ST_BERN) begin
            case (r_step)
                4'd0: r_s2 <= prod_rnd;
                4'd1: r_t2 <= prod_rnd;
                4'd2: r_b0 <= prod_rnd;
                4'd3: r_b1 <= prod_rnd3;
                4'd4: r_b2 <= prod_rnd3;
                4'd5: r_b3 <= prod_rnd;
                default: begin
                    if (step_m6[0]) begin
                        r_cy <= r_cy + CW'(prod);
                    end else begin
                        r_cx <= r_cx + CW'(prod);
                    end
                end
            endcase
        end
        if (r_state == ST_ROUND) begin
            r_x     <= COORD_W'(x_full);
            r_y     <= COORD_W'(y_full);
            r_left  <= (x_full == '0) ? '0 : COORD_W'(x_full - XW'(1));
            r_upper <= (y_full == '0) ? '0 : COORD_W'(y_full - XW'(1));
            r_wl    <= TW'(wl_full);
            r_wr    <= ONE_T - TW'(wl_full);
            r_wh    <= TW'(wh_full);
            r_wlow  <= ONE_T - TW'(wh_full);
        end
        if (r_state == ST_READ) begin
            r_amt <= prod255[2*T_FRAC_BITS +: BYTE_W];
        end
        if (r_state == ST_WRITE) begin
            o_pixel_x   <= col;
            o_pixel_y   <= row;
            o_new_value <= pix_ok ? sat : '0;
            o_in_frame  <= pix_ok;
            o_last      <= (r_pix == 2'd3);
        end
    end

endmodule
`default_nettype wire
